// ----- rtl/core/xrr_pkg.sv -----
// Shared types, constants and helpers for the xoshiro128** range unit.
// No dependencies; imported by xoshiro128_random_range_unit.
package xrr_pkg;

    localparam int unsigned WordW = 32;

    localparam logic [WordW-1:0] LcgMult = 32'd1664525;
    localparam logic [WordW-1:0] LcgInc  = 32'd1013904223;
    localparam logic [WordW-1:0] ScrMul5 = 32'd5;
    localparam logic [WordW-1:0] ScrMul9 = 32'd9;

    localparam int unsigned WarmSteps = 8;
    localparam int unsigned WarmCntW  = $clog2(WarmSteps);
    localparam int unsigned NumWords  = 4;
    localparam int unsigned WordIdxW  = $clog2(NumWords);

    localparam logic FUNC_RESEED = 1'b0;
    localparam logic FUNC_DRAW   = 1'b1;

    typedef logic [NumWords-1:0][WordW-1:0] words_t;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_SEED_MUL = 9'b000000010,
        ST_SEED_ADD = 9'b000000100,
        ST_WARM     = 9'b000001000,
        ST_DRAW_M5  = 9'b000010000,
        ST_DRAW_M9  = 9'b000100000,
        ST_DRAW_MS  = 9'b001000000,
        ST_DRAW_SUM = 9'b010000000,
        ST_FINISH   = 9'b100000000
    } state_t;

    function automatic logic [WordW-1:0] rotl7(input logic [WordW-1:0] v);
        return {v[WordW-8:0], v[WordW-1:WordW-7]};
    endfunction

    // One xoshiro128 state transition.
    function automatic words_t xs_advance(input words_t w);
        logic [WordW-1:0] sh;
        logic [WordW-1:0] t2;
        logic [WordW-1:0] t3;
        words_t           n;
        sh   = w[1] << 9;
        t2   = w[2] ^ w[0];
        t3   = w[3] ^ w[1];
        n[1] = w[1] ^ t2;
        n[0] = w[0] ^ t3;
        n[2] = t2 ^ sh;
        n[3] = {t3[WordW-12:0], t3[WordW-1:WordW-11]};
        return n;
    endfunction

endpackage

// ----- rtl/core/xoshiro128_random_range_unit.sv -----
// Top level of the xoshiro128** generator with ranged draw.
// Depends on xrr_pkg for constants, the state encoding and the transition.
//
// A draw (func 1) walks the scrambler and range states and a reseed
// (func 0) the seeding and warm-up states: one 32x32 multiplier, shared by the
// scrambler (x5, x9), the range scaling and the seeding LCG, is used once
// per cycle under the sequencer, and the eight warm-up transitions run one
// per cycle. s_ready is high only while the sequencer is idle; a finished
// result sits in the m_ register so the next item can be taken before it is
// collected, and a later result waits in the sequencer for as long as that
// register stays occupied. The range may be inverted; the span then wraps
// modulo 2^64.
module xoshiro128_random_range_unit
    import xrr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [WordW-1:0] cfg_wr_data,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             s_func,
    input  logic [WordW-1:0] s_range_low,
    input  logic [WordW-1:0] s_range_high,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [WordW-1:0] m_value
);

    state_t                state_reg, state_next;
    words_t                gen_reg, gen_next;
    logic [WordW-1:0]      seed_reg;
    logic [WordW-1:0]      x_reg, x_next;
    logic [WordIdxW-1:0]   seed_idx_reg, seed_idx_next;
    logic [WarmCntW-1:0]   warm_cnt_reg, warm_cnt_next;
    logic [2*WordW-1:0]    prod_reg;
    logic [WordW-1:0]      r_reg, r_next;
    logic [WordW-1:0]      lo_reg, lo_next;
    logic [WordW-1:0]      span_lo_reg, span_lo_next;
    logic                  span_neg_reg, span_neg_next;
    logic                  span_one_reg, span_one_next;
    logic [WordW-1:0]      result_reg, result_next;
    logic                  m_valid_reg, m_valid_next;
    logic [WordW-1:0]      m_value_reg, m_value_next;

    logic                  mul_en;
    logic [WordW-1:0]      mul_a;
    logic [WordW-1:0]      mul_b;
    logic [WordW+1:0]      span_ext;
    logic [WordW-1:0]      corr;
    logic                  in_xfer;
    logic                  out_free;

    assign s_ready  = (state_reg == ST_IDLE);
    assign in_xfer  = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_value  = m_value_reg;

    // span = high - low + 1, sign extended to 64 bits in pieces
    assign span_ext = {2'b00, s_range_high} - {2'b00, s_range_low} + {{(WordW+1){1'b0}}, 1'b1};

    // r times the upper span word: zero, r, or -r
    always_comb begin
        if (span_neg_reg) begin
            corr = ~r_reg + {{(WordW-1){1'b0}}, 1'b1};
        end else if (span_one_reg) begin
            corr = r_reg;
        end else begin
            corr = '0;
        end
    end

    // Shared multiplier operand select
    always_comb begin
        mul_en = 1'b1;
        mul_a  = prod_reg[WordW-1:0];
        mul_b  = span_lo_reg;
        case (state_reg)
            ST_SEED_MUL: begin
                mul_a = x_reg;
                mul_b = LcgMult;
            end
            ST_DRAW_M5: begin
                mul_a = gen_reg[1];
                mul_b = ScrMul5;
            end
            ST_DRAW_M9: begin
                mul_a = rotl7(prod_reg[WordW-1:0]);
                mul_b = ScrMul9;
            end
            ST_DRAW_MS: begin
                mul_a = prod_reg[WordW-1:0];
                mul_b = span_lo_reg;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        gen_next      = gen_reg;
        x_next        = x_reg;
        seed_idx_next = seed_idx_reg;
        warm_cnt_next = warm_cnt_reg;
        r_next        = r_reg;
        lo_next       = lo_reg;
        span_lo_next  = span_lo_reg;
        span_neg_next = span_neg_reg;
        span_one_next = span_one_reg;
        result_next   = result_reg;
        m_valid_next  = m_valid_reg;
        m_value_next  = m_value_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (in_xfer) begin
                    lo_next       = s_range_low;
                    span_lo_next  = span_ext[WordW-1:0];
                    span_neg_next = span_ext[WordW+1];
                    span_one_next = span_ext[WordW];
                    x_next        = seed_reg;
                    seed_idx_next = '0;
                    warm_cnt_next = '0;
                    state_next    = (s_func == FUNC_DRAW) ? ST_DRAW_M5 : ST_SEED_MUL;
                end
            end
            ST_SEED_MUL: begin
                state_next = ST_SEED_ADD;
            end
            ST_SEED_ADD: begin
                x_next                = prod_reg[WordW-1:0] + LcgInc;
                gen_next[seed_idx_reg] = x_next;
                if (seed_idx_reg == WordIdxW'(NumWords - 1)) begin
                    state_next = ST_WARM;
                end else begin
                    seed_idx_next = seed_idx_reg + 1'b1;
                    state_next    = ST_SEED_MUL;
                end
            end
            ST_WARM: begin
                gen_next      = xs_advance(gen_reg);
                warm_cnt_next = warm_cnt_reg + 1'b1;
                if (warm_cnt_reg == WarmCntW'(WarmSteps - 1)) begin
                    result_next = '0;
                    state_next  = ST_FINISH;
                end
            end
            ST_DRAW_M5: begin
                state_next = ST_DRAW_M9;
            end
            ST_DRAW_M9: begin
                gen_next   = xs_advance(gen_reg);
                state_next = ST_DRAW_MS;
            end
            ST_DRAW_MS: begin
                // prod_reg holds the scrambled output r here
                r_next     = prod_reg[WordW-1:0];
                state_next = ST_DRAW_SUM;
            end
            ST_DRAW_SUM: begin
                result_next = prod_reg[2*WordW-1:WordW] + corr + lo_reg;
                state_next  = ST_FINISH;
            end
            ST_FINISH: begin
                // hold until the output register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_value_next = result_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            gen_reg     <= {32'd4, 32'd3, 32'd2, 32'd1};
            seed_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            gen_reg     <= gen_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= {{WordW{1'b0}}, mul_a} * {{WordW{1'b0}}, mul_b};
        end
        x_reg        <= x_next;
        seed_idx_reg <= seed_idx_next;
        warm_cnt_reg <= warm_cnt_next;
        r_reg        <= r_next;
        lo_reg       <= lo_next;
        span_lo_reg  <= span_lo_next;
        span_neg_reg <= span_neg_next;
        span_one_reg <= span_one_next;
        result_reg   <= result_next;
        m_value_reg  <= m_value_next;
    end

    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        in_xfer |=> state_reg != ST_IDLE)
        else $error("sequencer stayed idle after an input transfer");

    a_seed_to_warm: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEED_ADD && seed_idx_reg == WordIdxW'(NumWords - 1))
        |=> (state_reg == ST_WARM && warm_cnt_reg == '0))
        else $error("warm-up did not start cleanly after seeding");

    a_finish_loads: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && out_free)
        |=> (m_valid_reg && state_reg == ST_IDLE && m_value_reg == $past(result_reg)))
        else $error("result not loaded into output register");

    a_reseed_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FINISH && $past(state_reg) == ST_WARM) |-> result_reg == '0)
        else $error("reseed result is not zero");

endmodule

// ----- verif/xrr_value_checker.sv -----
// Result checker for xoshiro128_random_range_unit: watches the seed write port and
// both channels, predicts every result from its own copy of the generator state.
// Depends on xrr_pkg for widths, the function codes and the arithmetic constants.
module xrr_value_checker
    import xrr_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_wr_en,
    input  logic [WordW-1:0] cfg_wr_data,
    input  logic             s_valid,
    input  logic             s_ready,
    input  logic             s_func,
    input  logic [WordW-1:0] s_range_low,
    input  logic [WordW-1:0] s_range_high,
    input  logic             m_valid,
    input  logic             m_ready,
    input  logic [WordW-1:0] m_value,
    output int               fail_count,
    output int               pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [WordW-1:0] gen_w [NumWords];
    logic [WordW-1:0] seed_copy;
    logic [WordW-1:0] expected_values [$];

    function automatic logic [WordW-1:0] rol(input logic [WordW-1:0] v, input int unsigned n);
        return (v << n) | (v >> (WordW - n));
    endfunction

    // Advance the four words once and return the scrambled output.
    function automatic logic [WordW-1:0] advance_words();
        logic [WordW-1:0] out;
        logic [WordW-1:0] shifted;
        out = rol(gen_w[1] * ScrMul5, 7) * ScrMul9;
        shifted = gen_w[1] << 9;
        gen_w[2] = gen_w[2] ^ gen_w[0];
        gen_w[3] = gen_w[3] ^ gen_w[1];
        gen_w[1] = gen_w[1] ^ gen_w[2];
        gen_w[0] = gen_w[0] ^ gen_w[3];
        gen_w[2] = gen_w[2] ^ shifted;
        gen_w[3] = rol(gen_w[3], 11);
        return out;
    endfunction

    function automatic void reload_words();
        logic [WordW-1:0] x;
        x = seed_copy;
        for (int i = 0; i < NumWords; i++) begin
            x = x * LcgMult + LcgInc;
            gen_w[i] = x;
        end
        for (int i = 0; i < WarmSteps; i++) begin
            void'(advance_words());
        end
    endfunction

    // Span and product wrap modulo 2^64, so an inverted range is defined too.
    function automatic logic [WordW-1:0] ranged_draw(input logic [WordW-1:0] lo,
                                                     input logic [WordW-1:0] hi);
        logic [63:0]      span;
        logic [63:0]      product;
        logic [WordW-1:0] r;
        r = advance_words();
        span = {32'd0, hi} - {32'd0, lo} + 64'd1;
        product = {32'd0, r} * span;
        return product[63:32] + lo;
    endfunction

    always @(posedge aclk) begin
        logic [WordW-1:0] want;
        if (!aresetn) begin
            gen_w[0] = 32'd1;
            gen_w[1] = 32'd2;
            gen_w[2] = 32'd3;
            gen_w[3] = 32'd4;
            seed_copy = '0;
            expected_values.delete();
            fail_count = 0;
            pending = 0;
        end else begin
            if (cfg_wr_en) begin
                seed_copy = cfg_wr_data;
            end
            // Check the result side first: a transfer at this edge belongs to an older item.
            if (m_valid && m_ready) begin
                if (expected_values.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: m_value %h with no item outstanding", $realtime, m_value);
                    end
                    fail_count++;
                end else begin
                    want = expected_values.pop_front();
                    if (m_value !== want) begin
                        if (fail_count < 10) begin
                            $display("%0t: m_value mismatch: expected %h, got %h",
                                     $realtime, want, m_value);
                        end
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                if (s_func == FUNC_RESEED) begin
                    reload_words();
                    expected_values.push_back('0);
                end else begin
                    expected_values.push_back(ranged_draw(s_range_low, s_range_high));
                end
            end
            pending = expected_values.size();
        end
    end

endmodule

// ----- verif/testbench.sv -----
// Top of the xoshiro128_random_range_unit bench: clock, reset, seed writes, draw and
// reseed stimulus with random gaps and back-pressure, and the verdict.
// Depends on xrr_pkg and on xrr_value_checker, which does all prediction and comparison.
module testbench
    import xrr_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int StallLimit  = 2000;
    localparam int PhaseItems  = 357;
    localparam int SqueezeLen  = 80;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [WordW-1:0] cfg_wr_data;
    logic             s_valid;
    logic             s_ready;
    logic             s_func;
    logic [WordW-1:0] s_range_low;
    logic [WordW-1:0] s_range_high;
    logic             m_valid;
    logic             m_ready;
    logic [WordW-1:0] m_value;

    int fail_count;
    int pending;
    bit steady_run;
    bit squeeze_armed;
    bit squeeze_done;

    xoshiro128_random_range_unit DUT (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value)
    );

    xrr_value_checker checker_i (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_func       (s_func),
        .s_range_low  (s_range_low),
        .s_range_high (s_range_high),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_value      (m_value),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic offer_item(input logic f, input logic [WordW-1:0] lo,
                              input logic [WordW-1:0] hi);
        @(negedge aclk);
        while (!steady_run && $urandom_range(0, 99) < 6) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_func       <= f;
        s_range_low  <= lo;
        s_range_high <= hi;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic random_item();
        logic [WordW-1:0] lo;
        logic [WordW-1:0] hi;
        lo = $urandom();
        hi = $urandom();
        if ($urandom_range(0, 99) < 8) begin
            offer_item(FUNC_RESEED, lo, hi);
        end else begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: ;
                4, 5: hi = lo + $urandom_range(0, 15);
                6: begin
                    lo = '0;
                    hi = '1;
                end
                7: hi = lo;
                8: begin
                    lo = $urandom_range(0, 255);
                    hi = '1 - $urandom_range(0, 255);
                end
                default: lo = hi + $urandom_range(1, 255);
            endcase
            offer_item(FUNC_DRAW, lo, hi);
        end
    endtask

    // Release the input, then let every outstanding result arrive and the unit go idle.
    task automatic settle();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (25) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [WordW-1:0] v);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
    endtask

    // Receiver: random stalls, one long hold-off when armed.
    initial begin
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (squeeze_armed && !squeeze_done) begin
                m_ready <= 1'b0;
                repeat (SqueezeLen - 1) @(negedge aclk);
                squeeze_done = 1'b1;
            end else begin
                m_ready <= steady_run || ($urandom_range(0, 99) >= 6);
            end
        end
    end

    // Watchdog: end the run when nothing transfers for too long.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < StallLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [WordW-1:0] phase_seed [4];
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        s_valid       = 1'b0;
        s_func        = FUNC_DRAW;
        s_range_low   = '0;
        s_range_high  = '0;
        steady_run    = 1'b0;
        squeeze_armed = 1'b0;
        squeeze_done  = 1'b0;
        phase_seed[0] = 32'hFFFF_FFFF;
        phase_seed[1] = $urandom();
        phase_seed[2] = 32'h0000_0000;
        phase_seed[3] = $urandom();

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: draws from the reset state, range corners, reseed with the reset seed.
        offer_item(FUNC_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'h0000_0000, 32'h0000_0000);
        offer_item(FUNC_DRAW, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'hFFFF_FFFF, 32'h0000_0000);
        offer_item(FUNC_DRAW, 32'h0000_0001, 32'h0000_0000);
        offer_item(FUNC_DRAW, 32'h8000_0000, 32'h7FFF_FFFF);
        offer_item(FUNC_DRAW, 32'd100, 32'd200);
        offer_item(FUNC_RESEED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'd0, 32'd9);
        settle();
        write_seed(32'hFFFF_FFFF);
        offer_item(FUNC_RESEED, 32'h0000_0000, 32'h0000_0000);
        offer_item(FUNC_DRAW, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'hAAAA_AAAA, 32'h5555_5555);
        offer_item(FUNC_DRAW, 32'h5555_5555, 32'hAAAA_AAAA);
        offer_item(FUNC_RESEED, 32'h1234_5678, 32'h8765_4321);
        offer_item(FUNC_RESEED, 32'h0000_0000, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'hFFFF_FFFE, 32'hFFFF_FFFF);
        offer_item(FUNC_DRAW, 32'h0000_0000, 32'h0000_0001);

        for (int p = 0; p < 4; p++) begin
            settle();
            write_seed(phase_seed[p]);
            offer_item(FUNC_RESEED, $urandom(), $urandom());
            for (int n = 0; n < PhaseItems; n++) begin
                steady_run = (p == 2) && (n < 200);
                // Hold off the receiver while the sender keeps offering.
                if (p == 1 && n == 100) begin
                    squeeze_armed = 1'b1;
                end
                random_item();
            end
            steady_run = 1'b0;
        end

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
